>>> src/bcrp_pkg.sv
`default_nettype none

package bcrp_pkg;

  // Field widths of the item and result channels.
  localparam int FIRST_W  = 6;
  localparam int SUM1_W   = 7;
  localparam int SECOND_W = 24;
  localparam int PRED_W   = 15;
  localparam int LIM1_W   = 7;
  localparam int CFG_W    = 24;

  // Second metric value that means no path is known.
  localparam logic [SECOND_W-1:0] INF = {SECOND_W{1'b1}};

  // Item opcodes; the fourth code is ignored.
  typedef enum logic [1:0] {
    OP_RELAX   = 2'd0,
    OP_EXTRACT = 2'd1,
    OP_CLEAR   = 2'd2
  } opcode_t;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_LIMIT_FIRST  = 1'b0,
    REG_LIMIT_SECOND = 1'b1
  } reg_idx_t;

  // One table slot as held in the memory.
  typedef struct packed {
    logic                mark;
    logic [SECOND_W-1:0] best;
    logic [PRED_W-1:0]   pred;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // One front entry on its way to the result channel.
  typedef struct packed {
    logic [FIRST_W-1:0]  first;
    logic [SECOND_W-1:0] second;
    logic [PRED_W-1:0]   pred;
    logic                ext;
  } front_entry_t;

  // Requests from the scan to the result buffer.
  typedef struct packed {
    logic         emit;
    logic         flush;
    front_entry_t entry;
  } emit_t;

endpackage

`default_nettype wire

>>> src/bcrp_ram.sv
`default_nettype none

module bcrp_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port; a read of the entry being
  // written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> src/bcrp_front.sv
`default_nettype none

module bcrp_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire bcrp_pkg::emit_t ev,
  output logic                out_free,
  output logic                m_tvalid,
  input  wire logic           m_tready,
  // m_tdata: front_first[5:0], front_second[29:6], front_pred[44:30],
  //          extendable[45], zero fill [47:46]
  output logic [47:0]         m_tdata,
  output logic                m_tlast,
  // m_tuser: entry_valid
  output logic                m_tuser
);

  bcrp_pkg::front_entry_t pend;
  logic                   pend_v;
  bcrp_pkg::front_entry_t outq;
  logic                   out_entry_valid;
  logic                   out_last;

  // The output register can take a new result at this edge.
  assign out_free = !m_tvalid || m_tready;

  // Control: a front entry is only known to be the final one when the scan
  // ends, so each entry waits in the pending register for the next one.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      pend_v   <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (ev.emit) begin
        pend_v <= 1'b1;
        if (pend_v) begin
          m_tvalid <= 1'b1;
        end
      end else if (ev.flush) begin
        pend_v   <= 1'b0;
        m_tvalid <= 1'b1;
      end
    end
  end

  // Payload of the pending and output registers.
  always_ff @(posedge clk) begin
    if (ev.emit) begin
      pend <= ev.entry;
      if (pend_v) begin
        outq            <= pend;
        out_entry_valid <= 1'b1;
        out_last        <= 1'b0;
      end
    end else if (ev.flush) begin
      out_last <= 1'b1;
      if (pend_v) begin
        outq            <= pend;
        out_entry_valid <= 1'b1;
      end else begin
        outq            <= '0;
        out_entry_valid <= 1'b0;
      end
    end
  end

  assign m_tdata = {2'b00, outq.ext, outq.pred, outq.second, outq.first};
  assign m_tlast = out_last;
  assign m_tuser = out_entry_valid;

endmodule

`default_nettype wire

>>> src/bicriteria_relax_pareto_front.sv
`default_nettype none

// Pareto-front relaxation table for one destination.
// Items arrive on the s_ channel: s_tuser carries the opcode and s_tdata the
// path and edge metrics with the predecessor node. Front entries leave on the
// m_ channel, one transfer each; m_tlast marks the final entry of an extract
// and m_tuser is low only on the single marker of an empty front.
// Relax and clear items are taken one per cycle while the block idles and
// give no result. A relax reads its slot and writes it back in the next
// cycle; a relax that hits the slot written in the same cycle takes the
// new value through a bypass. An extract holds off further items while it
// reads every slot of the memory in turn. The scan advances one slot per
// cycle in which the output register can be loaded, so a stalled receiver
// stalls the scan and no entry is lost. The user must write the limits
// through cfg_we/cfg_addr/cfg_wdata only while the block idles; the block
// itself does not enforce this.
// Reset is synchronous: it restores the limits and clears the slot valid
// flip-flops at once, so every slot reads as infinity with no mark; there is
// no clearing pass and the block takes items in the first cycle after reset.
module bicriteria_relax_pareto_front #(
  parameter int DICT_SIZE = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // s_tdata: path_first[5:0], path_second[29:6], edge_first[35:30],
  //          edge_second[59:36], from_node[74:60], zero fill [79:75]
  input  wire logic [79:0] s_tdata,
  // s_tuser: opcode
  input  wire logic [1:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // m_tdata: front_first[5:0], front_second[29:6], front_pred[44:30],
  //          extendable[45], zero fill [47:46]
  output logic [47:0]      m_tdata,
  output logic             m_tlast,
  // m_tuser: entry_valid
  output logic             m_tuser,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_addr,
  input  wire logic [23:0] cfg_wdata
);

  localparam int AW = (DICT_SIZE > 1) ? $clog2(DICT_SIZE) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(DICT_SIZE - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FLUSH
  } state_t;

  state_t state;

  logic [bcrp_pkg::LIM1_W-1:0]   limit_first;
  logic [bcrp_pkg::SECOND_W-1:0] limit_second;

  // Slot valid bits; a slot that is not valid reads as infinity, no mark.
  logic [DICT_SIZE-1:0] valid;

  // Input fields.
  logic [bcrp_pkg::FIRST_W-1:0]  path_first;
  logic [bcrp_pkg::SECOND_W-1:0] path_second;
  logic [bcrp_pkg::FIRST_W-1:0]  edge_first;
  logic [bcrp_pkg::SECOND_W-1:0] edge_second;
  logic [bcrp_pkg::PRED_W-1:0]   from_node;

  assign path_first  = s_tdata[5:0];
  assign path_second = s_tdata[29:6];
  assign edge_first  = s_tdata[35:30];
  assign edge_second = s_tdata[59:36];
  assign from_node   = s_tdata[74:60];

  logic                            acc;
  logic                            acc_relax;
  logic                            acc_extract;
  logic                            acc_clear;
  logic [bcrp_pkg::SUM1_W-1:0]     sum1;
  logic [bcrp_pkg::SECOND_W:0]     sum2;
  logic                            sum_ok;

  // Stage: the slot whose memory data is present this cycle.
  logic                            st_v;
  logic                            st_scan;
  logic                            st_last;
  logic [AW-1:0]                   st_idx;
  logic                            st_ok;
  logic [bcrp_pkg::SECOND_W-1:0]   st_s2;
  logic [bcrp_pkg::PRED_W-1:0]     st_pred;
  logic                            byp_v;
  bcrp_pkg::entry_t                byp_data;
  logic                            st_done;
  logic                            stage_free;

  logic [AW-1:0]                   rd_ptr;
  logic                            rd_more;
  logic                            scan_issue;
  logic                            rd_en;
  logic [AW-1:0]                   rd_addr;
  logic [bcrp_pkg::ENTRY_W-1:0]    ram_q;
  bcrp_pkg::entry_t                ram_entry;
  bcrp_pkg::entry_t                eff;

  logic                            wr_en;
  logic [AW-1:0]                   wr_addr;
  bcrp_pkg::entry_t                wr_data;

  logic [bcrp_pkg::SECOND_W-1:0]   bound;
  bcrp_pkg::emit_t                 ev;
  logic                            out_free;

  // Input handshake and decode.
  assign s_tready = (state == S_IDLE);
  assign acc      = s_tvalid && s_tready;

  always_comb begin
    acc_relax   = 1'b0;
    acc_extract = 1'b0;
    acc_clear   = 1'b0;
    case (s_tuser)
      bcrp_pkg::OP_RELAX:   acc_relax   = acc;
      bcrp_pkg::OP_EXTRACT: acc_extract = acc;
      bcrp_pkg::OP_CLEAR:   acc_clear   = acc;
      default: ;
    endcase
  end

  // Metric sums and the range checks of a relax.
  assign sum1   = {1'b0, path_first} + {1'b0, edge_first};
  assign sum2   = {1'b0, path_second} + {1'b0, edge_second};
  assign sum_ok = (sum1 < bcrp_pkg::SUM1_W'(DICT_SIZE)) && (sum1 < limit_first) &&
                  (sum2 < {1'b0, limit_second});

  // The stage finishes at once for a relax, and for a scan slot when the
  // result buffer can take whatever the slot produces.
  assign st_done    = st_v && (!st_scan || out_free);
  assign stage_free = !st_v || st_done;
  assign scan_issue = (state == S_SCAN) && rd_more && stage_free;
  assign rd_en      = acc_relax || acc_extract || scan_issue;

  always_comb begin
    if (acc_relax) begin
      rd_addr = sum1[AW-1:0];
    end else if (acc_extract) begin
      rd_addr = '0;
    end else begin
      rd_addr = rd_ptr;
    end
  end

  bcrp_ram #(
    .WIDTH (bcrp_pkg::ENTRY_W),
    .DEPTH (DICT_SIZE)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  assign ram_entry = ram_q;

  // Slot contents as seen by the stage: bypass, memory or reset value.
  always_comb begin
    if (byp_v) begin
      eff = byp_data;
    end else if (valid[st_idx]) begin
      eff = ram_entry;
    end else begin
      eff.mark = 1'b0;
      eff.best = bcrp_pkg::INF;
      eff.pred = ram_entry.pred;
    end
  end

  // Update of a relaxed slot, and mark clearing plus front test in a scan.
  always_comb begin
    wr_en            = 1'b0;
    wr_addr          = st_idx;
    wr_data          = eff;
    ev.emit          = 1'b0;
    ev.flush         = (state == S_FLUSH) && out_free;
    ev.entry.first   = bcrp_pkg::FIRST_W'(st_idx);
    ev.entry.second  = eff.best;
    ev.entry.pred    = eff.pred;
    ev.entry.ext     = eff.mark;
    if (st_v && !st_scan) begin
      if (st_ok && (eff.best > st_s2)) begin
        wr_en        = 1'b1;
        wr_data.mark = 1'b1;
        wr_data.best = st_s2;
        wr_data.pred = st_pred;
      end
    end else if (st_done) begin
      if (eff.mark) begin
        wr_en        = 1'b1;
        wr_data.mark = 1'b0;
      end
      ev.emit = (eff.best < bound);
    end
  end

  bcrp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .ev       (ev),
    .out_free (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  // Control state: sequencer, stage valid, slot valid bits and limits.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      st_v         <= 1'b0;
      byp_v        <= 1'b0;
      rd_more      <= 1'b0;
      valid        <= '0;
      limit_first  <= bcrp_pkg::LIM1_W'(64);
      limit_second <= bcrp_pkg::INF;
    end else begin
      if (st_done) begin
        st_v <= 1'b0;
      end
      if (rd_en) begin
        st_v    <= 1'b1;
        st_scan <= !acc_relax;
        st_last <= (rd_addr == LAST_IDX);
        st_idx  <= rd_addr;
        // A write to the slot being read lands after the read; keep it.
        byp_v   <= wr_en && (wr_addr == rd_addr);
      end

      if (acc_extract) begin
        rd_ptr  <= AW'(1);
        rd_more <= 1'b1;
      end else if (scan_issue) begin
        rd_ptr  <= rd_ptr + AW'(1);
        rd_more <= (rd_ptr != LAST_IDX);
      end

      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (acc_clear) begin
        valid <= '0;
      end

      case (state)
        S_IDLE: begin
          if (acc_extract) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (st_done && st_scan && st_last) begin
            state <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      if (cfg_we) begin
        case (cfg_addr)
          bcrp_pkg::REG_LIMIT_FIRST:  limit_first  <= cfg_wdata[bcrp_pkg::LIM1_W-1:0];
          bcrp_pkg::REG_LIMIT_SECOND: limit_second <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // Stage payload and front bound.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      byp_data <= wr_data;
    end
    if (acc_relax) begin
      st_ok   <= sum_ok;
      st_s2   <= sum2[bcrp_pkg::SECOND_W-1:0];
      st_pred <= from_node;
    end
    if (acc_extract) begin
      bound <= bcrp_pkg::INF;
    end else if (ev.emit) begin
      bound <= eff.best;
    end
  end

  // A relax writes back only while no extract is running.
  a_relax_write_idle: assert property (@(posedge clk) disable iff (rst)
    (wr_en && !st_scan) |-> (state == S_IDLE))
    else $error("relax write-back during an extract");

  // The end of the output flush always shows a final result.
  a_flush_last: assert property (@(posedge clk) disable iff (rst)
    (state == S_FLUSH && out_free) |=> (m_tvalid && m_tlast))
    else $error("extract ended without a final result");

  // A real front entry never carries infinity.
  a_entry_finite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[29:6] != bcrp_pkg::INF))
    else $error("front entry with infinite second metric");

  // The empty-front marker is final and carries zeros.
  a_marker_form: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tlast && (m_tdata == '0)))
    else $error("malformed empty-front marker");

endmodule

`default_nettype wire

>>> tb/bicriteria_relax_pareto_front_tb.sv
module bicriteria_relax_pareto_front_tb;

  localparam int DICT = 64;
  localparam int DRAIN_CYCLES = DICT + 8;
  localparam int LIMIT_CYCLES = 400000;
  localparam int DIR_N = 22;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 14;
  // The fourth opcode has no package name; the block must ignore it.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // One front entry as seen on the result channel.
  typedef struct packed {
    logic [bcrp_pkg::FIRST_W-1:0]  first;
    logic [bcrp_pkg::SECOND_W-1:0] second;
    logic [bcrp_pkg::PRED_W-1:0]   pred;
    logic                          ext;
    logic                          valid;
    logic                          last;
  } front_res_t;

  // One row of the directed table; res is used only when typed is set.
  typedef struct packed {
    logic [1:0]                    op;
    logic [bcrp_pkg::FIRST_W-1:0]  pf;
    logic [bcrp_pkg::SECOND_W-1:0] ps;
    logic [bcrp_pkg::FIRST_W-1:0]  ef;
    logic [bcrp_pkg::SECOND_W-1:0] es;
    logic [bcrp_pkg::PRED_W-1:0]   node;
    logic                          typed;
    front_res_t                    res;
  } stim_row_t;

  localparam front_res_t EMPTY_FRONT = '{6'd0, 24'd0, 15'd0, 1'b0, 1'b0, 1'b1};
  localparam front_res_t NO_RES = '0;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic        m_tlast;
  logic        m_tuser;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_addr = '0;
  logic [23:0] cfg_wdata = '0;

  // Shadow copy of the table and the limits.
  logic [bcrp_pkg::SECOND_W-1:0] best_tab [DICT];
  logic [bcrp_pkg::PRED_W-1:0]   pred_tab [DICT];
  logic                          mark_tab [DICT];
  logic [bcrp_pkg::LIM1_W-1:0]   lim_first;
  logic [bcrp_pkg::SECOND_W-1:0] lim_second;

  front_res_t front_q [$];
  stim_row_t  dir_tab [DIR_N];
  logic       item_typed = 1'b0;
  front_res_t item_res = '0;
  bit         quiet = 1'b0;
  int         errors = 0;
  int         cycles = 0;
  int         stall_left = 0;

  bicriteria_relax_pareto_front #(.DICT_SIZE(DICT)) uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Run ends with a failure if the traffic never completes.
  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("[bicriteria_relax_pareto_front] ERROR");
      $finish;
    end
  end

  // Receiver stalls in random bursts, none once the run goes quiet.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      m_tready = 1'b0;
    end else if (!quiet && $urandom_range(0, 15) == 0) begin
      stall_left = $urandom_range(1, 19) - 1;
      m_tready = 1'b0;
    end else begin
      m_tready = 1'b1;
    end
  end

  task automatic reset_table();
    for (int i = 0; i < DICT; i++) begin
      best_tab[i] = bcrp_pkg::INF;
      pred_tab[i] = '0;
      mark_tab[i] = 1'b0;
    end
    lim_first = 7'd64;
    lim_second = bcrp_pkg::INF;
  endtask

  // Updates the shadow table for one item and queues the front it produces.
  task automatic apply_item(input logic [1:0] op, input logic [79:0] d,
                            input logic typed, input front_res_t typed_res);
    logic [6:0]                    sum_first;
    logic [24:0]                   sum_second;
    logic [bcrp_pkg::SECOND_W-1:0] bound;
    front_res_t                    run_q [$];
    front_res_t                    r;
    case (op)
      bcrp_pkg::OP_RELAX: begin
        sum_first = {1'b0, d[5:0]} + {1'b0, d[35:30]};
        sum_second = {1'b0, d[29:6]} + {1'b0, d[59:36]};
        if (sum_first < DICT && sum_first < lim_first && sum_second < {1'b0, lim_second}
            && sum_second[23:0] < best_tab[sum_first[5:0]]) begin
          best_tab[sum_first[5:0]] = sum_second[23:0];
          pred_tab[sum_first[5:0]] = d[74:60];
          mark_tab[sum_first[5:0]] = 1'b1;
        end
      end
      bcrp_pkg::OP_EXTRACT: begin
        bound = bcrp_pkg::INF;
        for (int i = 0; i < DICT; i++) begin
          if (best_tab[i] < bound) begin
            bound = best_tab[i];
            r = '{i[5:0], bound, pred_tab[i], mark_tab[i], 1'b1, 1'b0};
            run_q.push_back(r);
          end
          mark_tab[i] = 1'b0;
        end
        if (run_q.size() == 0) begin
          run_q.push_back(EMPTY_FRONT);
        end else begin
          run_q[run_q.size() - 1].last = 1'b1;
        end
        if (typed) begin
          front_q.push_back(typed_res);
        end else begin
          foreach (run_q[k]) front_q.push_back(run_q[k]);
        end
      end
      bcrp_pkg::OP_CLEAR: begin
        for (int i = 0; i < DICT; i++) begin
          best_tab[i] = bcrp_pkg::INF;
          mark_tab[i] = 1'b0;
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors = errors + 1;
    end
  endtask

  // Shadow state follows register writes and item transfers, then each
  // result transfer is compared with the oldest queued front entry.
  always @(posedge clk) begin : monitor
    front_res_t want;
    if (!rst) begin
      if (cfg_we) begin
        if (cfg_addr == bcrp_pkg::REG_LIMIT_FIRST) lim_first = cfg_wdata[bcrp_pkg::LIM1_W-1:0];
        else lim_second = cfg_wdata;
      end
      if (s_tvalid && s_tready) apply_item(s_tuser, s_tdata, item_typed, item_res);
      if (m_tvalid && m_tready) begin
        if (front_q.size() == 0) begin
          $error("front entry transfer with nothing expected: tdata 0x%0h", m_tdata);
          errors = errors + 1;
        end else begin
          want = front_q.pop_front();
          check_field("front_first", 32'(want.first), 32'(m_tdata[5:0]));
          check_field("front_second", 32'(want.second), 32'(m_tdata[29:6]));
          check_field("front_pred", 32'(want.pred), 32'(m_tdata[44:30]));
          check_field("extendable", 32'(want.ext), 32'(m_tdata[45]));
          check_field("entry_valid", 32'(want.valid), 32'(m_tuser));
          check_field("last", 32'(want.last), 32'(m_tlast));
        end
      end
    end
  end

  // Presents one item, after an optional random gap, and waits for its transfer.
  task automatic send_item(input logic [1:0] op, input logic [5:0] pf, input logic [23:0] ps,
                           input logic [5:0] ef, input logic [23:0] es,
                           input logic [14:0] node, input logic typed,
                           input front_res_t res);
    int gap;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 19);
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser = op;
    s_tdata = {5'b0, node, es, ef, ps, pf};
    item_typed = typed;
    item_res = res;
    do @(posedge clk); while (!s_tready);
  endtask

  // Lets the block go idle: every front entry in, then the scan latency.
  task automatic settle();
    @(negedge clk);
    s_tvalid = 1'b0;
    item_typed = 1'b0;
    while (front_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_limits(input logic [6:0] l1, input logic [23:0] l2);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_addr = bcrp_pkg::REG_LIMIT_FIRST;
    cfg_wdata = {17'd0, l1};
    @(negedge clk);
    cfg_addr = bcrp_pkg::REG_LIMIT_SECOND;
    cfg_wdata = l2;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Random item of one phase; most relaxes stay inside the table.
  task automatic send_random(output bit counted);
    int          pick;
    logic [1:0]  op;
    logic [5:0]  pf, ef;
    logic [23:0] ps, es;
    pick = $urandom_range(0, 99);
    if (pick < 72) op = bcrp_pkg::OP_RELAX;
    else if (pick < 86) op = bcrp_pkg::OP_EXTRACT;
    else if (pick < 92) op = bcrp_pkg::OP_CLEAR;
    else op = OP_UNUSED;
    if ($urandom_range(0, 3) == 0) begin
      pf = 6'($urandom_range(0, 63));
      ef = 6'($urandom_range(0, 63));
      ps = 24'($urandom_range(0, 16777214));
      es = 24'($urandom_range(0, 16777214));
    end else begin
      pf = 6'($urandom_range(0, 40));
      ef = 6'($urandom_range(0, 23));
      ps = 24'($urandom_range(0, 3000));
      es = 24'($urandom_range(0, 3000));
    end
    send_item(op, pf, ps, ef, es, 15'($urandom_range(0, 32767)), 1'b0, NO_RES);
    counted = (op != OP_UNUSED);
  endtask

  logic [6:0]  phase_l1 [PHASES];
  logic [23:0] phase_l2 [PHASES];

  initial begin
    bit counted;
    int sent;
    reset_table();
    dir_tab = '{
      '{bcrp_pkg::OP_EXTRACT, 6'd0, 24'd0, 6'd0, 24'd0, 15'd0, 1'b1, EMPTY_FRONT},
      '{bcrp_pkg::OP_RELAX, 6'd0, 24'd0, 6'd0, 24'd0, 15'h7FFF, 1'b0, NO_RES},
      '{bcrp_pkg::OP_EXTRACT, 6'd0, 24'd0, 6'd0, 24'd0, 15'd0, 1'b1,
        '{6'd0, 24'd0, 15'h7FFF, 1'b1, 1'b1, 1'b1}},
      '{bcrp_pkg::OP_EXTRACT, 6'd0, 24'd0, 6'd0, 24'd0, 15'd0, 1'b1,
        '{6'd0, 24'd0, 15'h7FFF, 1'b0, 1'b1, 1'b1}},
      '{bcrp_pkg::OP_CLEAR, 6'h3F, 24'hFFFFFE, 6'h3F, 24'hFFFFFE, 15'h7FFF, 1'b0, NO_RES},
      '{bcrp_pkg::OP_EXTRACT, 6'h3F, 24'hFFFFFE, 6'h3F, 24'hFFFFFE, 15'h7FFF, 1'b1,
        EMPTY_FRONT},
      '{bcrp_pkg::OP_RELAX, 6'd63, 24'hFFFFFE, 6'd0, 24'd0, 15'd0, 1'b0, NO_RES},
      // An equal second sum must leave the predecessor alone.
      '{bcrp_pkg::OP_RELAX, 6'd0, 24'd0, 6'd63, 24'hFFFFFE, 15'h1234, 1'b0, NO_RES},
      '{bcrp_pkg::OP_EXTRACT, 6'd0, 24'd0, 6'd0, 24'd0, 15'd0, 1'b1,
        '{6'd63, 24'hFFFFFE, 15'd0, 1'b1, 1'b1, 1'b1}},
      // First sums past the table and a second sum at the limit are dropped.
      '{bcrp_pkg::OP_RELAX, 6'd63, 24'd0, 6'd1, 24'd0, 15'h1111, 1'b0, NO_RES},
      '{bcrp_pkg::OP_RELAX, 6'd63, 24'd0, 6'd63, 24'd0, 15'h1111, 1'b0, NO_RES},
      '{bcrp_pkg::OP_RELAX, 6'd1, 24'hFFFFFE, 6'd0, 24'd1, 15'h2222, 1'b0, NO_RES},
      '{bcrp_pkg::OP_RELAX, 6'd0, 24'hFFFFFE, 6'd0, 24'hFFFFFE, 15'h2222, 1'b0, NO_RES},
      '{bcrp_pkg::OP_RELAX, 6'd10, 24'd100, 6'd0, 24'd0, 15'h0AAA, 1'b0, NO_RES},
      '{bcrp_pkg::OP_RELAX, 6'd5, 24'd50, 6'd5, 24'd100, 15'h2222, 1'b0, NO_RES},
      '{bcrp_pkg::OP_RELAX, 6'd4, 24'd100, 6'd5, 24'd100, 15'h3333, 1'b0, NO_RES},
      '{OP_UNUSED, 6'h3F, 24'hFFFFFE, 6'h3F, 24'hFFFFFE, 15'h7FFF, 1'b0, NO_RES},
      '{bcrp_pkg::OP_RELAX, 6'd20, 24'd30, 6'd12, 24'd20, 15'h5555, 1'b0, NO_RES},
      '{bcrp_pkg::OP_EXTRACT, 6'd0, 24'd0, 6'd0, 24'd0, 15'd0, 1'b0, NO_RES},
      '{bcrp_pkg::OP_EXTRACT, 6'd0, 24'd0, 6'd0, 24'd0, 15'd0, 1'b0, NO_RES},
      '{bcrp_pkg::OP_CLEAR, 6'd0, 24'd0, 6'd0, 24'd0, 15'd0, 1'b0, NO_RES},
      '{bcrp_pkg::OP_EXTRACT, 6'd0, 24'd0, 6'd0, 24'd0, 15'd0, 1'b1, EMPTY_FRONT}
    };
    phase_l1 = '{7'd64, 7'd0, 7'd33, 7'd1, 7'd64, 7'd0};
    phase_l2 = '{24'hFFFFFF, 24'd0, 24'd5000, 24'd1, 24'd1000000, 24'd0};
    phase_l1[PHASES - 1] = 7'($urandom_range(0, 64));
    phase_l2[PHASES - 1] = 24'($urandom_range(0, 16777215));

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table under the reset limits.
    for (int i = 0; i < DIR_N; i++) begin
      send_item(dir_tab[i].op, dir_tab[i].pf, dir_tab[i].ps, dir_tab[i].ef,
                dir_tab[i].es, dir_tab[i].node, dir_tab[i].typed, dir_tab[i].res);
    end

    // Random phases, each under its own pair of limits; the last runs without idling.
    for (int p = 0; p < PHASES; p++) begin
      settle();
      set_limits(phase_l1[p], phase_l2[p]);
      if (p == PHASES - 1) quiet = 1'b1;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        send_random(counted);
        if (counted) sent = sent + 1;
      end
      send_item(bcrp_pkg::OP_EXTRACT, 6'($urandom_range(0, 63)),
                24'($urandom_range(0, 16777214)), 6'($urandom_range(0, 63)),
                24'($urandom_range(0, 16777214)), 15'($urandom_range(0, 32767)),
                1'b0, NO_RES);
    end

    settle();
    if (errors == 0) begin
      $display("[bicriteria_relax_pareto_front] OK");
    end else begin
      $display("[bicriteria_relax_pareto_front] ERROR");
    end
    $finish;
  end

endmodule
